>>> design/depqs_pkg.sv
`default_nettype none

package depqs_pkg;

  // Store size and field widths.
  localparam int CAPACITY    = 1024;
  localparam int KEY_BITS    = 20;
  localparam int VALUE_BITS  = 20;
  localparam int SUM_BITS    = 30;
  localparam int COUNT_BITS  = 11;

  // Internal occupancy counter can hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // Reduction tree: cells are combined in groups, then groups are combined.
  localparam int GROUP   = 32;
  localparam int NGROUPS = (CAPACITY + GROUP - 1) / GROUP;

  // Command codes carried in the action field.
  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_REM_MAX = 2'd1,
    ACT_REM_MIN = 2'd2
  } act_e;

  // Operation broadcast to every cell.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2
  } cell_op_e;

  typedef struct packed {
    logic [1:0]            action;
    logic [VALUE_BITS-1:0] entry_value;
    logic [KEY_BITS-1:0]   entry_key;
  } in_data_t;

  typedef struct packed {
    logic [SUM_BITS-1:0]   total_value;
    logic [SUM_BITS-1:0]   total_key;
    logic [COUNT_BITS-1:0] entry_count;
    logic                  accepted;
  } out_data_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  // Control broadcast from the sequencer to the cell chain.
  typedef struct packed {
    cell_op_e            op;
    entry_t              cmd;
    logic [CNT_W-1:0]    count;
  } cell_ctrl_t;

  // What each cell contributes to the OR reduction.
  typedef struct packed {
    logic   hit;
    entry_t tail;
  } red_t;

endpackage

`default_nettype wire

>>> design/double_ended_priority_queue_sum_top.sv
`default_nettype none

// Double-ended priority queue of (key, value) entries with distinct keys,
// held in ascending key order in a chain of cells, with running key and
// value sums. Each command beat gives one result beat. After acceptance a
// command passes through these steps before the block is ready again: the
// command is registered, every cell compares its key and the first level of
// the registered OR tree captures duplicate and tail information, the
// second tree level is registered, and the cells insert or shift and the
// result register is loaded. The update step waits while an earlier result
// is still held in the output register.
module double_ended_priority_queue_sum_top
  import depqs_pkg::*;
(
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  wire in_data_t  in_data_i,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output out_data_t      out_data_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_RED  = 4'b0100,
    S_UPD  = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  in_data_t            cmd_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [SUM_BITS-1:0] key_sum_q, key_sum_d;
  logic [SUM_BITS-1:0] value_sum_q, value_sum_d;
  logic                out_valid_q, out_valid_d;
  out_data_t           out_q;

  cell_ctrl_t ctrl;
  logic       cell_lt    [CAPACITY];
  entry_t     cell_entry [CAPACITY];
  red_t       cell_red   [CAPACITY];
  red_t       red;

  logic  commit;
  logic  ok;
  act_e  act;

  assign act        = act_e'(cmd_q.action);
  assign in_ready_o = (state_q == S_IDLE);
  assign commit     = (state_q == S_UPD) && (!out_valid_q || out_ready_i);

  // Decide whether the command changes the store.
  always_comb begin
    unique case (act)
      ACT_INSERT:  ok = !red.hit && (count_q != CNT_W'(CAPACITY));
      ACT_REM_MAX: ok = (count_q != '0);
      ACT_REM_MIN: ok = (count_q != '0);
      default:     ok = 1'b0;
    endcase
  end

  // Broadcast to the cells.
  always_comb begin
    ctrl.cmd   = '{key: cmd_q.entry_key, value: cmd_q.entry_value};
    ctrl.count = count_q;
    ctrl.op    = OP_HOLD;
    if (commit && ok) begin
      unique case (act)
        ACT_INSERT:  ctrl.op = OP_INSERT;
        ACT_REM_MIN: ctrl.op = OP_SHIFT;
        default:     ctrl.op = OP_HOLD;
      endcase
    end
  end

  // Chain of cells; the left end sees a smaller neighbor so it can take the
  // new entry, and the right end keeps its own entry on a shift.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   left_lt;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_left_end
      assign left_lt    = 1'b1;
      assign left_entry = cell_entry[i];
    end else begin : g_left
      assign left_lt    = cell_lt[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_right_end
      assign right_entry = cell_entry[i];
    end else begin : g_right
      assign right_entry = cell_entry[i+1];
    end

    depqs_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .idx_i         (CNT_W'(i)),
      .left_lt_i     (left_lt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .lt_o          (cell_lt[i]),
      .entry_o       (cell_entry[i]),
      .red_o         (cell_red[i])
    );
  end

  depqs_reduce u_reduce (
    .clk_i (clk_i),
    .red_i (cell_red),
    .red_o (red)
  );

  // Count and running sums.
  always_comb begin
    count_d     = count_q;
    key_sum_d   = key_sum_q;
    value_sum_d = value_sum_q;
    if (commit && ok) begin
      unique case (act)
        ACT_INSERT: begin
          count_d     = count_q + CNT_W'(1);
          key_sum_d   = key_sum_q + SUM_BITS'(cmd_q.entry_key);
          value_sum_d = value_sum_q + SUM_BITS'(cmd_q.entry_value);
        end
        ACT_REM_MAX: begin
          count_d     = count_q - CNT_W'(1);
          key_sum_d   = key_sum_q - SUM_BITS'(red.tail.key);
          value_sum_d = value_sum_q - SUM_BITS'(red.tail.value);
        end
        ACT_REM_MIN: begin
          count_d     = count_q - CNT_W'(1);
          key_sum_d   = key_sum_q - SUM_BITS'(cell_entry[0].key);
          value_sum_d = value_sum_q - SUM_BITS'(cell_entry[0].value);
        end
        default: begin
          count_d = count_q;
        end
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_CMP;
      S_CMP:   state_d = S_RED;
      S_RED:   state_d = S_UPD;
      S_UPD:   if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Output register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      key_sum_q   <= '0;
      value_sum_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      key_sum_q   <= key_sum_d;
      value_sum_q <= value_sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= in_data_i;
    end
    if (commit) begin
      out_q.total_value <= value_sum_d;
      out_q.total_key   <= key_sum_d;
      out_q.entry_count <= COUNT_BITS'(count_d);
      out_q.accepted    <= ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A command that took effect always moves the count.
  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && ok |=> count_q != $past(count_q))
    else $error("accepted command left the count unchanged");

  // A dropped command changes neither the count nor the sums.
  a_drop_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && !ok |=> $stable(count_q) && $stable(key_sum_q) && $stable(value_sum_q))
    else $error("dropped command changed the store state");

  // A committed result is offered on the output in the next cycle.
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_o)
    else $error("result not presented after update");

endmodule

`default_nettype wire

>>> design/depqs_cell.sv
`default_nettype none

module depqs_cell
  import depqs_pkg::*;
(
  input  wire              clk_i,
  input  wire cell_ctrl_t  ctrl_i,
  input  wire [CNT_W-1:0]  idx_i,
  input  wire              left_lt_i,
  input  wire entry_t      left_entry_i,
  input  wire entry_t      right_entry_i,
  output logic             lt_o,
  output entry_t           entry_o,
  output red_t             red_o
);

  entry_t entry_q, entry_d;
  logic   occupied;
  logic   is_tail;

  // Slot is live when it lies below the fill count.
  assign occupied = idx_i < ctrl_i.count;
  assign is_tail  = (ctrl_i.count != '0) && ((idx_i + CNT_W'(1)) == ctrl_i.count);

  // Compare the stored key against the command key.
  assign lt_o = occupied && (entry_q.key < ctrl_i.cmd.key);

  // Report a duplicate key, and hand out the entry when this is the last occupied slot.
  always_comb begin
    red_o.hit  = occupied && (entry_q.key == ctrl_i.cmd.key);
    red_o.tail = is_tail ? entry_q : '0;
  end

  // Insert: smaller keys stay, the first larger or free slot gets the new entry, the
  // rest take their left neighbor. Shift: every slot takes its right neighbor.
  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (lt_o) begin
          entry_d = entry_q;
        end else if (left_lt_i) begin
          entry_d = ctrl_i.cmd;
        end else begin
          entry_d = left_entry_i;
        end
      end
      OP_SHIFT: entry_d = right_entry_i;
      default:  entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

>>> design/depqs_reduce.sv
`default_nettype none

module depqs_reduce
  import depqs_pkg::*;
(
  input  wire        clk_i,
  input  wire red_t  red_i [CAPACITY],
  output red_t       red_o
);

  red_t grp_q [NGROUPS];
  red_t grp_d [NGROUPS];
  red_t top_q, top_d;

  // First level: OR the cells of each group.
  always_comb begin
    red_t acc;
    int   k;
    for (int g = 0; g < NGROUPS; g++) begin
      acc = '0;
      for (int j = 0; j < GROUP; j++) begin
        k = g * GROUP + j;
        if (k < CAPACITY) begin
          acc = red_t'(acc | red_i[k]);
        end
      end
      grp_d[g] = acc;
    end
  end

  // Second level: OR the group results.
  always_comb begin
    top_d = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      top_d = red_t'(top_d | grp_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    top_q <= top_d;
  end

  assign red_o = top_q;

endmodule

`default_nettype wire
